// ===== hw/rtl/rcd_pkg.sv =====
// Shared types, command words and drive table for the RC command decoder.
`default_nettype none

package rcd_pkg;

    localparam int BYTE_W  = 8;
    localparam int SPEED_W = 7;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

    // Four-character command words, first character in the top byte
    localparam logic [31:0] WORD_INIT  = "INIT";
    localparam logic [31:0] WORD_CMD0  = "CMD0";
    localparam logic [31:0] WORD_CMDA  = "CMDA";
    localparam logic [31:0] WORD_CMDB  = "CMDB";
    localparam logic [31:0] WORD_CMDC  = "CMDC";
    localparam logic [23:0] PREFIX_CMD = "CMD";

    localparam logic [BYTE_W-1:0] CHAR_ONE  = "1";
    localparam logic [BYTE_W-1:0] CHAR_NINE = "9";

    // Configuration register indexes
    localparam logic [1:0] CFG_FULL_SPEED = 2'd0;
    localparam logic [1:0] CFG_HALF_SPEED = 2'd1;
    localparam logic [1:0] CFG_TRIM_SPEED = 2'd2;

    // Byte position of the last byte of a command word
    localparam logic [1:0] LAST_BYTE_POS = 2'd3;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        SPD_ZERO = 2'd0,
        SPD_FULL = 2'd1,
        SPD_HALF = 2'd2,
        SPD_TRIM = 2'd3
    } spd_sel_t;

    typedef enum logic [3:0] {
        CODE_NONE   = 4'd0,
        CODE_INIT   = 4'd1,
        CODE_ENGINE = 4'd2,
        CODE_LIGHTS = 4'd3,
        CODE_HORN   = 4'd4,
        CODE_BRAKE  = 4'd5,
        CODE_DRIVE  = 4'd6,
        CODE_BAD    = 4'd7,
        CODE_UNK    = 4'd8
    } code_t;

    typedef struct packed {
        logic               engine;
        logic               lights;
        logic               horn;
        dir_t               ldir;
        logic [SPEED_W-1:0] lspd;
        dir_t               rdir;
        logic [SPEED_W-1:0] rspd;
    } rcd_state_t;

    typedef struct packed {
        dir_t     ldir;
        spd_sel_t lsel;
        dir_t     rdir;
        spd_sel_t rsel;
    } drive_entry_t;

    // Drive modes 1..9 at index 0..8
    function automatic drive_entry_t drive_entry(input logic [3:0] mode_idx);
        drive_entry_t e;
        unique case (mode_idx)
            4'd0:    e = '{DIR_IDLE, SPD_ZERO, DIR_IDLE, SPD_ZERO};
            4'd1:    e = '{DIR_FWD,  SPD_TRIM, DIR_FWD,  SPD_FULL};
            4'd2:    e = '{DIR_FWD,  SPD_HALF, DIR_FWD,  SPD_FULL};
            4'd3:    e = '{DIR_BACK, SPD_FULL, DIR_FWD,  SPD_FULL};
            4'd4:    e = '{DIR_BACK, SPD_HALF, DIR_BACK, SPD_FULL};
            4'd5:    e = '{DIR_BACK, SPD_FULL, DIR_BACK, SPD_FULL};
            4'd6:    e = '{DIR_BACK, SPD_FULL, DIR_BACK, SPD_HALF};
            4'd7:    e = '{DIR_FWD,  SPD_FULL, DIR_BACK, SPD_FULL};
            4'd8:    e = '{DIR_FWD,  SPD_FULL, DIR_FWD,  SPD_HALF};
            default: e = '{DIR_IDLE, SPD_ZERO, DIR_IDLE, SPD_ZERO};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rcd_decode.sv =====
// Command word matcher and next-state logic for the RC command decoder.
`default_nettype none

module rcd_decode
    import rcd_pkg::*;
(
    input  logic [BYTE_W-1:0]  rx_byte,
    input  logic [23:0]        head_bytes,
    input  logic               last_byte,
    input  rcd_state_t         state,
    input  logic [SPEED_W-1:0] full_speed,
    input  logic [SPEED_W-1:0] half_speed,
    input  logic [SPEED_W-1:0] trim_speed,
    output rcd_state_t         state_next,
    output code_t              code,
    output logic               stopped
);

    logic [31:0]  word;
    logic [3:0]   mode_idx;
    logic         is_digit;
    drive_entry_t entry;

    function automatic logic [SPEED_W-1:0] sat_speed(input logic [SPEED_W-1:0] v);
        return (v > SPEED_MAX) ? SPEED_MAX : v;
    endfunction

    function automatic logic [SPEED_W-1:0] pick_speed(
        input spd_sel_t           sel,
        input logic [SPEED_W-1:0] full_v,
        input logic [SPEED_W-1:0] half_v,
        input logic [SPEED_W-1:0] trim_v
    );
        logic [SPEED_W-1:0] r;
        unique case (sel)
            SPD_FULL: r = sat_speed(full_v);
            SPD_HALF: r = sat_speed(half_v);
            SPD_TRIM: r = sat_speed(trim_v);
            default:  r = '0;
        endcase
        return r;
    endfunction

    assign word     = {head_bytes, rx_byte};
    assign is_digit = (rx_byte >= CHAR_ONE) && (rx_byte <= CHAR_NINE);
    assign mode_idx = 4'(rx_byte - CHAR_ONE);
    assign entry    = drive_entry(mode_idx);

    always_comb
    begin
        state_next = state;
        code       = CODE_NONE;
        stopped    = 1'b0;
        if (last_byte)
        begin
            priority if (word == WORD_INIT)
            begin
                code = CODE_INIT;
            end
            else if (word == WORD_CMD0)
            begin
                code = CODE_ENGINE;
                state_next.engine = ~state.engine;
                if (state.engine)
                begin
                    // engine off stops both motors
                    state_next.ldir = DIR_IDLE;
                    state_next.lspd = '0;
                    state_next.rdir = DIR_IDLE;
                    state_next.rspd = '0;
                    stopped         = 1'b1;
                end
            end
            else if (word == WORD_CMDA)
            begin
                code = CODE_LIGHTS;
                state_next.lights = ~state.lights;
            end
            else if (word == WORD_CMDB)
            begin
                code = CODE_HORN;
                state_next.horn = ~state.horn;
            end
            else if (word == WORD_CMDC)
            begin
                code            = CODE_BRAKE;
                state_next.ldir = DIR_IDLE;
                state_next.lspd = '0;
                state_next.rdir = DIR_IDLE;
                state_next.rspd = '0;
                stopped         = 1'b1;
            end
            else if (head_bytes == PREFIX_CMD)
            begin
                if (is_digit)
                begin
                    code            = CODE_DRIVE;
                    state_next.ldir = entry.ldir;
                    state_next.lspd = pick_speed(entry.lsel, full_speed, half_speed,
                                                 trim_speed);
                    state_next.rdir = entry.rdir;
                    state_next.rspd = pick_speed(entry.rsel, full_speed, half_speed,
                                                 trim_speed);
                end
                else
                begin
                    code = CODE_BAD;
                end
            end
            else
            begin
                code = CODE_UNK;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rc_command_decoder_unit.sv =====
// Top level of the RC command decoder: input stage, decode stage and result register.
`default_nettype none

//  channel   handshake              payload
//  rx        rx_valid / rx_ready    rx_byte
//  res       res_valid / res_ready  echo_byte, command_done, command_code, engine_running,
//                                   lights_lit, horn_sounding, left/right_direction,
//                                   left/right_speed, motors_stopped
//  cfg       cfg_we (no wait)       cfg_index, cfg_data
//
//  res_valid rises once an accepted byte has passed the input register and the decode
//  stage into the result register; one item per cycle sustained while res_ready is high.
//  The rate is set by the combinational decode between the input register and the
//  result register, which also updates the car state.
//  Reset clears the byte counter, the car flags, the motor settings and both valids;
//  the speed registers return to 100, 50 and 93.
//  A stalled result holds the decode stage, which in turn holds rx_ready low.

module rc_command_decoder_unit
    import rcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               rx_valid,
    output logic               rx_ready,
    input  logic [BYTE_W-1:0]  rx_byte,

    output logic               res_valid,
    input  logic               res_ready,
    output logic [BYTE_W-1:0]  echo_byte,
    output logic               command_done,
    output logic [3:0]         command_code,
    output logic               engine_running,
    output logic               lights_lit,
    output logic               horn_sounding,
    output logic [1:0]         left_direction,
    output logic [SPEED_W-1:0] left_speed,
    output logic [1:0]         right_direction,
    output logic [SPEED_W-1:0] right_speed,
    output logic               motors_stopped,

    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [SPEED_W-1:0] cfg_data
);

    // Speed configuration
    logic [SPEED_W-1:0] full_speed_reg;
    logic [SPEED_W-1:0] half_speed_reg;
    logic [SPEED_W-1:0] trim_speed_reg;

    // Input stage
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;

    // Command assembly and car state
    logic [1:0]        byte_count_reg;
    logic [BYTE_W-1:0] cmd_bytes_reg [0:2];
    rcd_state_t        state_reg;

    // Result register
    logic              res_valid_reg;
    logic [BYTE_W-1:0] echo_reg;
    logic              done_reg;
    code_t             code_reg;
    rcd_state_t        out_state_reg;
    logic              stopped_reg;

    // Decode outputs
    rcd_state_t state_next;
    code_t      dec_code;
    logic       dec_stopped;
    logic       last_byte;

    logic res_take;
    logic dec_fire;

    // The result register frees up when empty or being taken this cycle.
    assign res_take  = !res_valid_reg || res_ready;
    assign rx_ready  = !s1_valid_reg || res_take;
    assign dec_fire  = s1_valid_reg && res_take;
    assign last_byte = (byte_count_reg == LAST_BYTE_POS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_speed_reg <= SPEED_MAX;
            half_speed_reg <= 7'd50;
            trim_speed_reg <= 7'd93;
        end
        else if (cfg_we)
        begin
            // index 3 is not a register and is dropped
            unique case (cfg_index)
                CFG_FULL_SPEED: full_speed_reg <= cfg_data;
                CFG_HALF_SPEED: half_speed_reg <= cfg_data;
                CFG_TRIM_SPEED: trim_speed_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx_ready)
        begin
            s1_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    rcd_decode u_decode (
        .rx_byte    (s1_byte_reg),
        .head_bytes ({cmd_bytes_reg[0], cmd_bytes_reg[1], cmd_bytes_reg[2]}),
        .last_byte  (last_byte),
        .state      (state_reg),
        .full_speed (full_speed_reg),
        .half_speed (half_speed_reg),
        .trim_speed (trim_speed_reg),
        .state_next (state_next),
        .code       (dec_code),
        .stopped    (dec_stopped)
    );

    // Car state and byte counter advance once per decoded item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 2'd0;
            state_reg      <= '{1'b0, 1'b0, 1'b0, DIR_IDLE, '0, DIR_IDLE, '0};
        end
        else if (dec_fire)
        begin
            byte_count_reg <= byte_count_reg + 2'd1;
            state_reg      <= state_next;
        end
    end

    // Held command bytes are never read before they are written.
    always_ff @(posedge clk)
    begin
        if (dec_fire && !last_byte)
        begin
            cmd_bytes_reg[byte_count_reg] <= s1_byte_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_fire)
        begin
            echo_reg      <= s1_byte_reg;
            done_reg      <= last_byte;
            code_reg      <= dec_code;
            out_state_reg <= state_next;
            stopped_reg   <= dec_stopped;
        end
    end

    assign res_valid       = res_valid_reg;
    assign echo_byte       = echo_reg;
    assign command_done    = done_reg;
    assign command_code    = code_reg;
    assign engine_running  = out_state_reg.engine;
    assign lights_lit      = out_state_reg.lights;
    assign horn_sounding   = out_state_reg.horn;
    assign left_direction  = out_state_reg.ldir;
    assign left_speed      = out_state_reg.lspd;
    assign right_direction = out_state_reg.rdir;
    assign right_speed     = out_state_reg.rspd;
    assign motors_stopped  = stopped_reg;

    // A code is reported exactly on the byte that completes a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (done_reg == (code_reg != CODE_NONE)))
        else $error("command code and completion flag disagree");

    // A stop report always comes with both motors idle at zero speed.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && stopped_reg |->
            (out_state_reg.ldir == DIR_IDLE) && (out_state_reg.rdir == DIR_IDLE) &&
            (out_state_reg.lspd == '0) && (out_state_reg.rspd == '0))
        else $error("motors reported stopped but still driven");

    // Motor speeds never exceed full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.lspd <= SPEED_MAX) && (state_reg.rspd <= SPEED_MAX))
        else $error("motor speed above 100 percent");

    // A stalled input stage keeps its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !res_take |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("input stage lost a stalled item");

    // The byte counter moves by one per decoded item and holds otherwise.
    assert property (@(posedge clk) disable iff (!rst_n)
        !dec_fire |=> $stable(byte_count_reg))
        else $error("byte counter moved without a decoded item");

endmodule

`default_nettype wire
